@@ src/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap free bit allocator package
// Shared widths, codes, controller states and the byte pick result type.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int IDX_W   = 12;
  localparam int LIMIT_W = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
  localparam logic [7:0]         FULL_BYTE   = 8'hFF;

  // Register word selects (paddr[2]).
  localparam logic REG_BIT_LIMIT = 1'b0;

  // Operation codes.
  localparam logic OP_FIND = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SET_RD,
    ST_SET_WR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic             nonfull;
    logic             hit;
    logic [IDX_W-1:0] index;
  } byte_pick_t;

endpackage

@@ src/bfa_map_ram.sv @@
// ----------------------------------------------------------------------------
// Bitmap byte memory
// Single-port byte memory with a registered read.
// ----------------------------------------------------------------------------
module bfa_map_ram #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  input  logic              we,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/bfa_byte_scan.sv @@
// ----------------------------------------------------------------------------
// Byte scan unit
// Finds the lowest clear bit of one bitmap byte and checks it against the
// active limit.
// ----------------------------------------------------------------------------
module bfa_byte_scan #(
  parameter int ADDR_W = 9,
  parameter int EL_W   = 13
) (
  input  logic [7:0]         byte_in,
  input  logic [ADDR_W-1:0]  byte_addr,
  input  logic [EL_W-1:0]    limit,
  output bfa_pkg::byte_pick_t pick
);

  localparam int N_W   = ADDR_W + 3;
  localparam int CMP_W = (N_W > EL_W) ? N_W : EL_W;
  localparam int NX_W  = (N_W > bfa_pkg::IDX_W) ? N_W : bfa_pkg::IDX_W;

  logic [2:0]       pos;
  logic [N_W-1:0]   num;
  logic [NX_W-1:0]  num_ext;

  always_comb begin
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!byte_in[i]) begin
        pos = 3'(i);
      end
    end
  end

  assign num     = {byte_addr, pos};
  assign num_ext = NX_W'(num);

  assign pick.nonfull = (byte_in != bfa_pkg::FULL_BYTE);
  assign pick.hit     = pick.nonfull && (CMP_W'(num) < CMP_W'(limit));
  assign pick.index   = num_ext[bfa_pkg::IDX_W-1:0];

endmodule

@@ src/bitmap_free_bit_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Bitmap free bit allocator
// Keeps a used-entry bitmap, finds the lowest free entry below the limit
// and marks entries used.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | beat
//  in       | in_valid, in_ready, in_operation,       | one request
//           | in_bit_index                            |
//  out      | out_valid, out_ready, out_found,        | one result
//           | out_free_index, out_index_error         |
//  cfg      | psel, penable, pwrite, paddr, pwdata,   | register write or read
//           | prdata, pready                          |
//
// A find reads one bitmap byte per cycle through the single memory port and
// stops at the first byte with a clear bit or after ceil(limit/8) bytes. A set
// reads the byte, modifies it and writes it back; a refused set does not.
// After reset a clearing pass writes MAP_BYTES bytes, one per cycle, while
// in_ready stays low. A result waiting on out_ready does not stop the next
// request from being accepted, only its completion.
// ----------------------------------------------------------------------------
module bitmap_free_bit_allocator_core #(
  parameter int BITMAP_BITS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [bfa_pkg::IDX_W-1:0]   in_bit_index,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [bfa_pkg::IDX_W-1:0]   out_free_index,
  output logic                        out_index_error,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int MAP_BYTES = (BITMAP_BITS + 7) / 8;
  localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAP_BYTES + 1);
  localparam int MB_W      = $clog2(BITMAP_BITS + 1);
  localparam int EL_W      = (MB_W > bfa_pkg::LIMIT_W) ? MB_W : bfa_pkg::LIMIT_W;
  localparam int IX_W      = (ADDR_W + 3 > bfa_pkg::IDX_W) ? ADDR_W + 3 : bfa_pkg::IDX_W;
  localparam logic [EL_W-1:0]  MAX_EL    = EL_W'(BITMAP_BITS);
  localparam logic [CNT_W-1:0] CLR_LAST  = CNT_W'(MAP_BYTES - 1);

  bfa_pkg::state_t state_r, state_nxt;

  logic [bfa_pkg::LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]            iss_cnt_r, iss_cnt_nxt;
  logic                        chk_ok_r, chk_ok_nxt;
  logic [ADDR_W-1:0]           chk_addr_r, chk_addr_nxt;
  logic [ADDR_W-1:0]           set_addr_r, set_addr_nxt;
  logic [2:0]                  set_bit_r, set_bit_nxt;
  logic                        res_found_r, res_found_nxt;
  logic [bfa_pkg::IDX_W-1:0]   res_index_r, res_index_nxt;
  logic                        res_error_r, res_error_nxt;
  logic                        out_valid_r;
  logic                        out_found_r;
  logic [bfa_pkg::IDX_W-1:0]   out_free_index_r;
  logic                        out_index_error_r;

  logic [EL_W-1:0]   limit_ext;
  logic [EL_W-1:0]   elim;
  logic [EL_W:0]     lim_sum;
  logic [CNT_W-1:0]  nbytes;
  logic [IX_W-1:0]   idx_ext;
  logic              idx_bad;
  logic              accept;
  logic              issue;
  logic              scan_last;
  logic              scan_done;
  logic              slot_free;
  logic              out_load;

  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  bfa_pkg::byte_pick_t pick;

  assign limit_ext = EL_W'(limit_r);
  assign elim      = (limit_ext > MAX_EL) ? MAX_EL : limit_ext;
  assign lim_sum   = (EL_W + 1)'(elim) + (EL_W + 1)'(7);
  assign nbytes    = CNT_W'(lim_sum >> 3);
  assign idx_ext   = IX_W'(in_bit_index);
  assign idx_bad   = (EL_W'(in_bit_index) >= elim);

  assign in_ready  = (state_r == bfa_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign issue     = (iss_cnt_r < nbytes);
  assign scan_last = ((CNT_W'(chk_addr_r) + CNT_W'(1)) == nbytes);
  assign scan_done = chk_ok_r && (pick.nonfull || scan_last);
  assign slot_free = !out_valid_r || out_ready;
  assign out_load  = (state_r == bfa_pkg::ST_RESULT) && slot_free;

  bfa_map_ram #(
    .DEPTH  (MAP_BYTES),
    .ADDR_W (ADDR_W)
  ) u_map_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bfa_byte_scan #(
    .ADDR_W (ADDR_W),
    .EL_W   (EL_W)
  ) u_byte_scan (
    .byte_in   (ram_rdata),
    .byte_addr (chk_addr_r),
    .limit     (elim),
    .pick      (pick)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfa_pkg::ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = bfa_pkg::ST_IDLE;
        end
      end
      bfa_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == bfa_pkg::OP_SET) begin
            state_nxt = idx_bad ? bfa_pkg::ST_RESULT : bfa_pkg::ST_SET_RD;
          end else begin
            state_nxt = (nbytes == '0) ? bfa_pkg::ST_RESULT : bfa_pkg::ST_SCAN;
          end
        end
      end
      bfa_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = bfa_pkg::ST_RESULT;
        end
      end
      bfa_pkg::ST_SET_RD: state_nxt = bfa_pkg::ST_SET_WR;
      bfa_pkg::ST_SET_WR: state_nxt = bfa_pkg::ST_RESULT;
      bfa_pkg::ST_RESULT: begin
        if (slot_free) begin
          state_nxt = bfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    iss_cnt_nxt   = iss_cnt_r;
    chk_ok_nxt    = 1'b0;
    chk_addr_nxt  = chk_addr_r;
    set_addr_nxt  = set_addr_r;
    set_bit_nxt   = set_bit_r;
    res_found_nxt = res_found_r;
    res_index_nxt = res_index_r;
    res_error_nxt = res_error_r;
    ram_addr      = '0;
    ram_we        = 1'b0;
    ram_wdata     = 8'h00;
    case (state_r)
      bfa_pkg::ST_CLEAR: begin
        ram_addr    = clr_cnt_r[ADDR_W-1:0];
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + CNT_W'(1);
      end
      bfa_pkg::ST_IDLE: begin
        if (accept) begin
          res_found_nxt = 1'b0;
          res_index_nxt = '0;
          res_error_nxt = (in_operation == bfa_pkg::OP_SET) && idx_bad;
          set_addr_nxt  = idx_ext[ADDR_W+2:3];
          set_bit_nxt   = in_bit_index[2:0];
          iss_cnt_nxt   = '0;
        end
      end
      bfa_pkg::ST_SCAN: begin
        ram_addr     = iss_cnt_r[ADDR_W-1:0];
        chk_ok_nxt   = issue;
        chk_addr_nxt = iss_cnt_r[ADDR_W-1:0];
        if (issue) begin
          iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
        end
        if (chk_ok_r && pick.nonfull) begin
          res_found_nxt = pick.hit;
          res_index_nxt = pick.hit ? pick.index : '0;
        end
      end
      bfa_pkg::ST_SET_RD: begin
        ram_addr = set_addr_r;
      end
      bfa_pkg::ST_SET_WR: begin
        ram_addr  = set_addr_r;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | (8'h01 << set_bit_r);
      end
      default: begin
        ram_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      chk_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= bfa_pkg::LIMIT_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      chk_ok_r  <= chk_ok_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite && pready && (paddr[2] == bfa_pkg::REG_BIT_LIMIT)) begin
        limit_r <= pwdata[bfa_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_cnt_r   <= iss_cnt_nxt;
    chk_addr_r  <= chk_addr_nxt;
    set_addr_r  <= set_addr_nxt;
    set_bit_r   <= set_bit_nxt;
    res_found_r <= res_found_nxt;
    res_index_r <= res_index_nxt;
    res_error_r <= res_error_nxt;
    if (out_load) begin
      out_found_r       <= res_found_r;
      out_free_index_r  <= res_index_r;
      out_index_error_r <= res_error_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_free_index  = out_free_index_r;
  assign out_index_error = out_index_error_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bfa_pkg::REG_BIT_LIMIT) ? 32'(limit_r) : 32'h0;

endmodule

@@ src/bfa_checker.sv @@
// ----------------------------------------------------------------------------
// Bitmap free bit allocator checker
// Port-level checks on the allocator core, attached by bind.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_found,
  input logic [bfa_pkg::IDX_W-1:0] out_free_index,
  input logic                      out_index_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped before it was taken.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_index_error))
    else $error("Result reports both a found entry and an index error.");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_free_index == '0)
    else $error("Free index is not zero on a result without a found entry.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request accepted in the cycle after another one.");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("Request accepted before the bitmap was cleared.");

endmodule

bind bitmap_free_bit_allocator_core bfa_checker u_bfa_checker (.*);
